@@ hw/rtl/twwm_pkg.sv @@
package twwm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRONT_WORD    = 2'd0;
	localparam logic [1:0] REG_FRONT_LENGTH  = 2'd1;
	localparam logic [1:0] REG_BEHIND_WORD   = 2'd2;
	localparam logic [1:0] REG_BEHIND_LENGTH = 2'd3;

	localparam int WORD_W  = 64;
	localparam int LEN_W   = 4;
	localparam int CHAR_W  = 8;
	localparam int OUT_W   = 16;
	localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

	// index into the totals delay line, word lengths stay at or below eight
	localparam int HIDX_W = 3;

	// classification queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = 2;
	localparam int QC_W        = 3;

	// one classified character
	typedef struct packed {
		logic               front_hit;
		logic               behind_hit;
		logic [HIDX_W-1:0]  behind_idx;
		logic               disabled;
		logic               last;
	} class_item_t;

	// queue status seen by the top level
	typedef struct packed {
		logic            full;
		logic            empty;
		logic [QC_W-1:0] count;
	} queue_stat_t;

endpackage

@@ hw/rtl/twwm_front.sv @@
module twwm_front #(
	parameter int MAX_WORD = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [twwm_pkg::CHAR_W-1:0]   in_char,
	input  logic                          in_last,
	input  logic                          queue_full,
	input  logic [twwm_pkg::WORD_W-1:0]   front_word,
	input  logic [twwm_pkg::LEN_W-1:0]    front_length,
	input  logic [twwm_pkg::WORD_W-1:0]   behind_word,
	input  logic [twwm_pkg::LEN_W-1:0]    behind_length,
	output logic                          push,
	output twwm_pkg::class_item_t         item
);
	import twwm_pkg::*;

	localparam int RDEPTH = (MAX_WORD > 1) ? MAX_WORD - 1 : 1;
	localparam int RW     = RDEPTH * CHAR_W;
	localparam int WIN_W  = MAX_WORD * CHAR_W;
	localparam int WI     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int SW     = $clog2(MAX_WORD + 1);

	logic [RW-1:0]        recent_q;
	logic [SW-1:0]        seen_q;
	logic [RW+CHAR_W-1:0] win_full;
	logic [WIN_W-1:0]     win;
	logic                 front_hit;
	logic                 behind_hit;

	// does a word of length len end at the newest character of the window
	function automatic logic word_hit(input logic [WORD_W-1:0] word,
			input logic [LEN_W-1:0] len, input logic [WIN_W-1:0] w,
			input logic [SW-1:0] seen);
		logic             hit;
		logic [LEN_W-1:0] back;
		hit = (len != '0) && (len <= LEN_W'(MAX_WORD)) &&
			((5'(seen) + 5'd1) >= {1'b0, len});
		for (int i = 0; i < MAX_WORD; i++) begin
			back = len - 4'd1 - 4'(i);
			if ((4'(i) < len) && ((word[8*i +: 8] == 8'd0) ||
					(word[8*i +: 8] != w[8*back[WI-1:0] +: 8]))) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	// window of the current character and the ones before it, newest lowest
	assign win_full = {recent_q, in_char};
	assign win      = win_full[WIN_W-1:0];

	// classify the character against both words
	always_comb begin
		front_hit  = word_hit(front_word, front_length, win, seen_q);
		behind_hit = word_hit(behind_word, behind_length, win, seen_q);
		push       = in_valid && !queue_full;
		item.front_hit  = front_hit;
		item.behind_hit = behind_hit;
		item.behind_idx = HIDX_W'(behind_length - 4'd1);
		item.disabled   = (front_length == '0) || (behind_length == '0);
		item.last       = in_last;
	end

	// character history, cleared after the last beat of a sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q   <= '0;
		end else if (push) begin
			if (in_last) begin
				recent_q <= '0;
				seen_q   <= '0;
			end else begin
				recent_q <= win_full[RW-1:0];
				if (seen_q < SW'(MAX_WORD)) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/twwm_queue.sv @@
module twwm_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  twwm_pkg::class_item_t  push_item,
	input  logic                   pop,
	output twwm_pkg::class_item_t  head_item,
	output twwm_pkg::queue_stat_t  stat
);
	import twwm_pkg::*;

	class_item_t     mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	// status and head
	always_comb begin
		stat.count = count_q;
		stat.full  = (count_q == QC_W'(QUEUE_DEPTH));
		stat.empty = (count_q == '0);
		head_item  = mem_q[rd_ptr_q];
	end

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/twwm_back.sv @@
module twwm_back #(
	parameter int MAX_WORD   = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  twwm_pkg::class_item_t        head_item,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [twwm_pkg::OUT_W-1:0]   out_count
);
	import twwm_pkg::*;

	localparam int HI = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int XW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] hist_q [MAX_WORD];
	logic [COUNT_BITS-1:0] paired_q;
	logic                  valid_q;
	logic [OUT_W-1:0]      count_q;

	logic [COUNT_BITS-1:0] total_n;
	logic [COUNT_BITS-1:0] paired_n;
	logic [XW-1:0]         paired_x;
	logic [OUT_W-1:0]      result;

	// take a beat unless a last beat would overwrite a waiting result
	assign pop = head_valid && (!head_item.last || !valid_q || out_ready);

	// next totals and saturated result, zero while a word is disabled
	always_comb begin
		paired_n = head_item.behind_hit ? hist_q[head_item.behind_idx[HI-1:0]] : paired_q;
		total_n  = (head_item.front_hit && (total_q != COUNT_MAX)) ?
			total_q + 1'b1 : total_q;
		paired_x = XW'(paired_n);
		if (head_item.disabled) begin
			result = '0;
		end else if (paired_x > XW'(OUT_MAX)) begin
			result = OUT_MAX;
		end else begin
			result = paired_x[OUT_W-1:0];
		end
	end

	// running totals and their delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			paired_q <= '0;
			for (int i = 0; i < MAX_WORD; i++) begin
				hist_q[i] <= '0;
			end
		end else if (pop) begin
			if (head_item.last) begin
				total_q  <= '0;
				paired_q <= '0;
				for (int i = 0; i < MAX_WORD; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				total_q  <= total_n;
				paired_q <= paired_n;
				hist_q[0] <= total_n;
				for (int i = 1; i < MAX_WORD; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && head_item.last) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			count_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign out_count = count_q;

endmodule

@@ hw/rtl/two_word_wildcard_match_counter.sv @@
// a count reaches m_tvalid once its last beat has passed through the queue and then
// the output register; earlier queued beats and an untaken count can hold it back
// throughput: one character per clock; a last beat waits at the queue head while the
// previous count is not yet taken, and s_tready drops once four beats are queued
// reset: arst_n clears history, totals, queue and configuration at once,
// no clearing pass; history also clears after every last beat
module two_word_wildcard_match_counter #(
	parameter int MAX_WORD   = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] text_char
	input  logic                           s_tlast,   // end_of_text
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // [15:0] match_count
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [twwm_pkg::WORD_W-1:0]    cfg_data
);
	import twwm_pkg::*;

	logic [WORD_W-1:0] front_word_q;
	logic [LEN_W-1:0]  front_length_q;
	logic [WORD_W-1:0] behind_word_q;
	logic [LEN_W-1:0]  behind_length_q;

	logic        push;
	logic        pop;
	class_item_t push_item;
	class_item_t head_item;
	queue_stat_t q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_word_q    <= '0;
			front_length_q  <= '0;
			behind_word_q   <= '0;
			behind_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRONT_WORD:    front_word_q    <= cfg_data;
				REG_FRONT_LENGTH:  front_length_q  <= cfg_data[LEN_W-1:0];
				REG_BEHIND_WORD:   behind_word_q   <= cfg_data;
				REG_BEHIND_LENGTH: behind_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// classifier
	twwm_front #(
		.MAX_WORD(MAX_WORD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_char      (s_tdata),
		.in_last      (s_tlast),
		.queue_full   (q_stat.full),
		.front_word   (front_word_q),
		.front_length (front_length_q),
		.behind_word  (behind_word_q),
		.behind_length(behind_length_q),
		.push         (push),
		.item         (push_item)
	);

	assign s_tready = !q_stat.full;

	// queue between classifier and counter
	twwm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.stat     (q_stat)
	);

	// counter and output register
	twwm_back #(
		.MAX_WORD  (MAX_WORD),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_stat.empty),
		.head_item (head_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_count (m_tdata)
	);

	// the counter never takes from an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// fill count stays within the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QC_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

	// a last beat taken from the queue shows a result next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.last) |=> m_tvalid)
		else $error("last beat gave no result");

endmodule
